FILE: sv/fps_pkg.sv
// Shared types and constants for the Fenwick prefix-sum tree.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fps_pkg;

  localparam int unsigned IDX_W        = 14;
  localparam int unsigned DATA_W       = 32;
  // A climbing position can pass the largest index by up to one stride.
  localparam int unsigned POS_W        = IDX_W + 1;
  // Wide enough to compare any position against any legal capacity.
  localparam int unsigned CMP_W        = 22;
  localparam int unsigned CAPACITY_DEF = 16384;

  localparam logic [IDX_W-1:0] SIZE_RESET = 14'd16383;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } fps_state_e;

endpackage

FILE: sv/fps_tree_mem.sv
// Single-clock tree word store: one write port, one read port, registered read.
// Depends on fps_pkg for the data width.
module fps_tree_mem #(
  parameter int unsigned DEPTH = fps_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [fps_pkg::DATA_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [fps_pkg::DATA_W-1:0]  rdata_o
);

  logic [fps_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [fps_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/fps_walker.sv
// Walk sequencer: clearing sweep, add and query walks over the tree store,
// and the result register. Depends on fps_pkg; drives fps_tree_mem.
module fps_walker #(
  parameter int unsigned CAPACITY = fps_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [fps_pkg::IDX_W-1:0]          active_size_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [fps_pkg::IDX_W-1:0]          index_i,
  input  logic signed [fps_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fps_pkg::DATA_W-1:0]  prefix_sum_o,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_waddr_o,
  output logic [fps_pkg::DATA_W-1:0]         mem_wdata_o,
  output logic [AW-1:0]                      mem_raddr_o,
  input  logic [fps_pkg::DATA_W-1:0]         mem_rdata_i
);

  localparam int unsigned POS_W = fps_pkg::POS_W;
  localparam int unsigned CMP_W = fps_pkg::CMP_W;
  localparam logic [CMP_W-1:0] CAP_C    = CMP_W'(CAPACITY);
  localparam logic [AW-1:0]    CLR_LAST = AW'(CAPACITY - 1);

  fps_pkg::fps_state_e state_q, state_d;

  logic [POS_W-1:0]           pos_q, pos_d;
  logic [fps_pkg::DATA_W-1:0] val_q, val_d;
  logic [fps_pkg::DATA_W-1:0] acc_q, acc_d;
  logic                       kind_q, kind_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic                       out_valid_q, out_valid_d;
  logic [fps_pkg::DATA_W-1:0] out_data_q, out_data_d;

  logic [POS_W-1:0] low_bit, pos_up, pos_dn;
  logic             pos_in_cap, up_ok, idx_ok, in_fire, out_free;

  assign low_bit    = pos_q & (~pos_q + POS_W'(1));
  assign pos_up     = pos_q + low_bit;
  assign pos_dn     = pos_q & ~low_bit;
  assign pos_in_cap = CMP_W'(pos_q) < CAP_C;
  assign up_ok      = (pos_up <= POS_W'(active_size_i)) && (CMP_W'(pos_up) < CAP_C);
  assign idx_ok     = (index_i != '0) && (index_i <= active_size_i)
                      && (CMP_W'(index_i) < CAP_C);
  assign in_fire    = in_valid_i && (state_q == fps_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fps_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = fps_pkg::ST_IDLE;
      end
      fps_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (kind_i == fps_pkg::KIND_QUERY) begin
            state_d = (index_i == '0) ? fps_pkg::ST_DONE : fps_pkg::ST_READ;
          end else if (idx_ok) begin
            state_d = fps_pkg::ST_READ;
          end
        end
      end
      fps_pkg::ST_READ: state_d = fps_pkg::ST_UPDATE;
      fps_pkg::ST_UPDATE: begin
        if (kind_q == fps_pkg::KIND_ADD) begin
          state_d = up_ok ? fps_pkg::ST_READ : fps_pkg::ST_IDLE;
        end else begin
          state_d = (pos_dn == '0) ? fps_pkg::ST_DONE : fps_pkg::ST_READ;
        end
      end
      fps_pkg::ST_DONE: begin
        if (out_free) state_d = fps_pkg::ST_IDLE;
      end
      default: state_d = fps_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory port and result register.
  always_comb begin
    pos_d       = pos_q;
    val_d       = val_q;
    acc_d       = acc_q;
    kind_d      = kind_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(pos_q);
    mem_wdata_o = mem_rdata_i + val_q;
    mem_raddr_o = AW'(pos_q);
    in_stall_o  = (state_q != fps_pkg::ST_IDLE);

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      fps_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
      end
      fps_pkg::ST_IDLE: begin
        if (in_fire) begin
          pos_d  = POS_W'(index_i);
          val_d  = value_i;
          kind_d = kind_i;
          acc_d  = '0;
        end
      end
      fps_pkg::ST_READ: begin
      end
      fps_pkg::ST_UPDATE: begin
        if (kind_q == fps_pkg::KIND_ADD) begin
          mem_we_o = 1'b1;
          pos_d    = pos_up;
        end else begin
          acc_d = acc_q + (pos_in_cap ? mem_rdata_i : '0);
          pos_d = pos_dn;
        end
      end
      fps_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fps_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    val_q      <= val_d;
    acc_q      <= acc_d;
    kind_q     <= kind_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign prefix_sum_o = out_data_q;

endmodule

FILE: sv/fenwick_prefix_sum_tree.sv
// Fenwick prefix-sum tree. Add: each visited node is read, then written back;
// the climb stops at the active size or the capacity. Query: each set bit of the
// index visits one node (read, then fold in), then the result register is loaded.
// Input takes the next transaction once a walk ends; an ignored add starts no walk.
// Reset: async active low; then a clearing sweep zeroes all CAPACITY words of the store,
// input stalled meanwhile, configuration writes still taken. Depends on fps_pkg.
module fenwick_prefix_sum_tree #(
  parameter int unsigned CAPACITY = fps_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: active size, written whenever the enable is high.
  input  logic                               cfg_we_i,
  input  logic [fps_pkg::IDX_W-1:0]          cfg_wdata_i,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [fps_pkg::IDX_W-1:0]          index_i,
  input  logic signed [fps_pkg::DATA_W-1:0]  value_i,
  // Result channel (queries only).
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fps_pkg::DATA_W-1:0]  prefix_sum_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  // Active size register: bounds the climb of an add walk. Queries ignore it.
  logic [fps_pkg::IDX_W-1:0] active_size_q, active_size_d;

  always_comb begin
    active_size_d = active_size_q;
    if (cfg_we_i) active_size_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= fps_pkg::SIZE_RESET;
    end else begin
      active_size_q <= active_size_d;
    end
  end

  // Memory port between the sequencer and the store.
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [fps_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [fps_pkg::DATA_W-1:0] mem_rdata;

  // The sequencer owns the whole walk: it reads a node in READ, and in UPDATE
  // either writes back node + amount (add) or folds the node into the
  // running sum (query). Read and write of one node never overlap with the
  // next node's read, so no forwarding is needed.
  fps_walker #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_size_i (active_size_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .prefix_sum_o  (prefix_sum_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // Tree store: one word per position, registered read.
  fps_tree_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: sv/fps_checker.sv
// Port-level checks of the Fenwick prefix-sum tree, bound to its top level.
// Depends on fps_pkg and on the top level's port list.
module fps_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [fps_pkg::IDX_W-1:0]          index_i,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [fps_pkg::DATA_W-1:0]  prefix_sum_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(prefix_sum_o))
    else $error("stalled result dropped or changed");

  // An accepted query always leaves idle (a walk, or the result at index zero), so input stalls next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == fps_pkg::KIND_QUERY |=> in_stall_o)
    else $error("input not stalled after a query");

  // An add at index zero is dropped and the block stays ready.
  a_add_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == fps_pkg::KIND_ADD && index_i == '0 |=> !in_stall_o)
    else $error("add at index zero started a walk");

  // A new result only comes out of a query, while input is stalled.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a walk");

endmodule

bind fenwick_prefix_sum_tree fps_checker u_fps_checker (.*);

FILE: sim/tb_fenwick_prefix_sum_tree.sv
// Self-checking testbench for fenwick_prefix_sum_tree: directed corner items, then random
// add/query traffic under several active sizes, with bursty input and a stalling result side.
// Depends on fps_pkg and the block's RTL only.
module tb_fenwick_prefix_sum_tree;
  timeunit 1ns;
  timeprecision 1ps;

  typedef bit [fps_pkg::IDX_W-1:0]  idx_t;
  typedef bit [fps_pkg::POS_W-1:0]  pos_t;
  typedef bit [fps_pkg::DATA_W-1:0] word_t;

  // Clearing sweep after reset is the longest quiet stretch a correct block shows.
  localparam int unsigned QUIET_LIMIT   = 4 * fps_pkg::CAPACITY_DEF;
  // Give a trailing add walk time to finish.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 230;

  // Shadow Fenwick tree: applies accepted adds, queues the sum of every accepted query.
  class prefix_sum_predictor;
    word_t       node_sum [fps_pkg::CAPACITY_DEF];
    idx_t        size_limit;
    word_t       pending_sums [$];
    int unsigned error_count;
    int unsigned sums_checked;

    function new();
      foreach (node_sum[i]) node_sum[i] = '0;
      size_limit   = fps_pkg::SIZE_RESET;
      error_count  = 0;
      sums_checked = 0;
    endfunction

    function void set_size(idx_t size);
      size_limit = size;
    endfunction

    function void note_item(logic kind, idx_t idx, word_t amount);
      pos_t  pos;
      word_t acc;
      pos = pos_t'(idx);
      acc = '0;
      if (kind == fps_pkg::KIND_ADD) begin
        // Index zero never climbs; the block drops it.
        if (pos != 0) begin
          while (pos <= size_limit && pos < fps_pkg::CAPACITY_DEF) begin
            node_sum[pos] += amount;
            pos += pos & (~pos + pos_t'(1));
          end
        end
      end else begin
        while (pos != 0) begin
          if (pos < fps_pkg::CAPACITY_DEF) acc += node_sum[pos];
          pos -= pos & (~pos + pos_t'(1));
        end
        pending_sums.push_back(acc);
      end
    endfunction

    function void check_sum(word_t got);
      word_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: prefix_sum expected none actual %0d", $time, $signed(got));
        error_count++;
      end else begin
        want = pending_sums.pop_front();
        if (want != got) begin
          $display("%0t: prefix_sum expected %0d actual %0d", $time, $signed(want),
                   $signed(got));
          error_count++;
        end
      end
      sums_checked++;
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [fps_pkg::IDX_W-1:0]         cfg_wdata_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              kind_i = fps_pkg::KIND_ADD;
  logic [fps_pkg::IDX_W-1:0]         index_i = '0;
  logic signed [fps_pkg::DATA_W-1:0] value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [fps_pkg::DATA_W-1:0] prefix_sum_o;

  prefix_sum_predictor fenwick_pred;
  int unsigned         quiet_cycles = 0;

  fenwick_prefix_sum_tree DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .prefix_sum_o (prefix_sum_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offer one transaction from a falling edge, hold it until taken, return at the next
  // falling edge with valid still high so back-to-back items need no extra toggle.
  task automatic send_item(logic kind, idx_t idx, word_t amount);
    in_valid_i = 1'b1;
    kind_i     = kind;
    index_i    = idx;
    value_i    = amount;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    fenwick_pred.note_item(kind, idx, amount);
    @(negedge clk_i);
  endtask

  task automatic pause_input(int unsigned cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_size(idx_t size);
    cfg_wdata_i = size;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    fenwick_pred.set_size(size);
  endtask

  // Hold input until every queued sum is back, then let a trailing add walk finish.
  task automatic drain_and_settle();
    in_valid_i = 1'b0;
    while (fenwick_pred.pending_sums.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Random adds and queries in bursts; indices lean toward the active range and its top
  // edge, with zero and full-width indices mixed in so every index bit toggles.
  task automatic run_random_phase(int unsigned count, idx_t size);
    int unsigned burst;
    int unsigned roll;
    logic        kind;
    idx_t        idx;
    word_t       amount;
    burst = $urandom_range(1, 48);
    repeat (count) begin
      kind = ($urandom_range(0, 1) == 0) ? fps_pkg::KIND_ADD : fps_pkg::KIND_QUERY;
      roll = $urandom_range(0, 99);
      if (roll < 8)
        idx = '0;
      else if (roll < 28 || size == 0)
        idx = idx_t'($urandom);
      else if (roll < 36)
        idx = size;
      else if (roll < 60)
        idx = idx_t'($urandom_range(1, (size < 32) ? size : 32));
      else
        idx = idx_t'($urandom_range(1, size));
      roll = $urandom_range(0, 99);
      if (roll < 60)
        amount = $urandom_range(0, 2000) - 1000;
      else if (roll < 90)
        amount = $urandom;
      else if (roll < 94)
        amount = 32'h7FFF_FFFF;
      else if (roll < 97)
        amount = 32'h8000_0000;
      else
        amount = 32'hFFFF_FFFF;
      send_item(kind, idx, amount);
      burst--;
      if (burst == 0) begin
        // Most bursts end in a gap; some run straight into the next one.
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 30));
        burst = $urandom_range(1, 48);
      end
    end
  endtask

  // Compare every result taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      fenwick_pred.check_sum(prefix_sum_o);
  end

  // Watchdog: end the run once nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o)
        || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fenwick_prefix_sum_tree: mismatch");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Result side: runs of random stall patterns, plus long hold-offs at set result counts
  // so the block backs up while the input side keeps offering.
  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned beat;
    int unsigned next_hold;
    next_hold = 100;
    beat      = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (fenwick_pred.sums_checked >= next_hold) begin
        out_stall_i = 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        next_hold += 500;
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 150);
      repeat (run) begin
        case (mode)
          0: begin
            out_stall_i = 1'b0;
          end
          1: begin
            out_stall_i = ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall_i = ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall_i = (beat % 3 == 0);
          end
        endcase
        beat++;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    idx_t phase_size [8];
    fenwick_pred = new();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Full size, written while the clearing sweep still runs.
    write_size(14'd16383);
    send_item(fps_pkg::KIND_QUERY, 14'd0, 32'h1234_5678);
    send_item(fps_pkg::KIND_ADD, 14'd0, 32'd12345);
    send_item(fps_pkg::KIND_QUERY, 14'd16383, 32'd0);
    send_item(fps_pkg::KIND_ADD, 14'd1, 32'h7FFF_FFFF);
    send_item(fps_pkg::KIND_ADD, 14'd16383, 32'h8000_0000);
    send_item(fps_pkg::KIND_ADD, 14'd8192, 32'hFFFF_FFFF);
    send_item(fps_pkg::KIND_QUERY, 14'd1, 32'd0);
    send_item(fps_pkg::KIND_QUERY, 14'd8191, 32'd0);
    send_item(fps_pkg::KIND_QUERY, 14'd8192, 32'd0);
    send_item(fps_pkg::KIND_QUERY, 14'd16383, 32'd0);
    // Add one more at the top index and query the total again.
    send_item(fps_pkg::KIND_ADD, 14'd16383, 32'd1);
    send_item(fps_pkg::KIND_QUERY, 14'd16383, 32'hDEAD_BEEF);
    send_item(fps_pkg::KIND_ADD, 14'd10922, 32'h5555_5555);
    send_item(fps_pkg::KIND_QUERY, 14'd5461, 32'hAAAA_AAAA);
    send_item(fps_pkg::KIND_QUERY, 14'd10922, 32'd0);

    // Size zero: every add dropped, queries still read the store.
    drain_and_settle();
    write_size(14'd0);
    send_item(fps_pkg::KIND_ADD, 14'd5, 32'd7);
    send_item(fps_pkg::KIND_QUERY, 14'd16383, 32'd0);
    send_item(fps_pkg::KIND_QUERY, 14'd5, 32'd0);

    // Size one: only node 1 takes adds; queries above the size walk the old store.
    drain_and_settle();
    write_size(14'd1);
    send_item(fps_pkg::KIND_ADD, 14'd1, 32'd3);
    send_item(fps_pkg::KIND_ADD, 14'd2, 32'd9);
    send_item(fps_pkg::KIND_QUERY, 14'd1, 32'd0);
    send_item(fps_pkg::KIND_QUERY, 14'd2, 32'd0);

    // Mid size: add above the size dropped, add walk cut short at the size.
    drain_and_settle();
    write_size(14'd100);
    send_item(fps_pkg::KIND_ADD, 14'd100, 32'hFFFF_FFFB);
    send_item(fps_pkg::KIND_ADD, 14'd101, 32'd11);
    send_item(fps_pkg::KIND_ADD, 14'd64, 32'd1000);
    send_item(fps_pkg::KIND_QUERY, 14'd127, 32'd0);
    send_item(fps_pkg::KIND_QUERY, 14'd16000, 32'd0);

    phase_size[0] = 14'd16383;
    phase_size[1] = 14'd37;
    phase_size[2] = 14'd1;
    phase_size[3] = idx_t'($urandom_range(2, 16382));
    phase_size[4] = 14'd0;
    phase_size[5] = idx_t'($urandom_range(1000, 4000));
    phase_size[6] = 14'd16382;
    phase_size[7] = 14'd16383;
    foreach (phase_size[p]) begin
      drain_and_settle();
      write_size(phase_size[p]);
      run_random_phase(PHASE_ITEMS, phase_size[p]);
    end

    drain_and_settle();
    if (fenwick_pred.error_count == 0 && fenwick_pred.pending_sums.size() == 0)
      $display("fenwick_prefix_sum_tree: match");
    else
      $display("fenwick_prefix_sum_tree: mismatch");
    $finish;
  end

endmodule

FILE: fenwick_prefix_sum_tree.f
sv/fps_pkg.sv
sv/fps_tree_mem.sv
sv/fps_walker.sv
sv/fenwick_prefix_sum_tree.sv
sv/fps_checker.sv
sim/tb_fenwick_prefix_sum_tree.sv
